// ----- src/rd256_pkg.sv -----
// Rijndael-256 shared types, S-box and round helpers
package rd256_pkg;

    localparam int NumRoundsDefault = 14;
    localparam int KeyRegCount      = 4;
    localparam int CfgIndexWidth    = 2;
    localparam int BlockWidth       = 256;

    localparam logic [CfgIndexWidth-1:0] REG_KEY_0_7   = 2'd0;
    localparam logic [CfgIndexWidth-1:0] REG_KEY_8_15  = 2'd1;
    localparam logic [CfgIndexWidth-1:0] REG_KEY_16_23 = 2'd2;
    localparam logic [CfgIndexWidth-1:0] REG_KEY_24_31 = 2'd3;

    typedef logic [BlockWidth-1:0] block_t;
    typedef logic [7:0]            byte_t;

    function automatic byte_t sbox(input byte_t a);
        byte_t r;
        unique case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r=8'h00;
        endcase
        return r;
    endfunction

    function automatic byte_t xtime(input byte_t a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // byte n of the block sits at bits 8n+7:8n (row n%4, column n/4)
    function automatic block_t sub_shift(input block_t s);
        block_t o;
        int     src;
        for (int c = 0; c < 8; c++) begin
            for (int r = 0; r < 4; r++) begin
                // rows 1,2,3 rotate left by 1,3,4 columns
                src = 4 * ((c + ((r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 3 : 4)) % 8) + r;
                o[8*(4*c+r) +: 8] = sbox(s[8*src +: 8]);
            end
        end
        return o;
    endfunction

    function automatic block_t mix_cols(input block_t s);
        block_t o;
        byte_t  a0, a1, a2, a3, al;
        for (int c = 0; c < 8; c++) begin
            a0 = s[32*c +: 8];
            a1 = s[32*c+8 +: 8];
            a2 = s[32*c+16 +: 8];
            a3 = s[32*c+24 +: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            o[32*c +: 8]    = a0 ^ al ^ xtime(a0 ^ a1);
            o[32*c+8 +: 8]  = a1 ^ al ^ xtime(a1 ^ a2);
            o[32*c+16 +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            o[32*c+24 +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        return o;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // next 8-word schedule group from the previous one
    function automatic block_t next_keys(input block_t k, input byte_t rcon);
        block_t      o;
        logic [31:0] t;
        t = sub_word(k[255:224]);
        t = {t[7:0], t[31:8]} ^ {24'h0, rcon};
        o[31:0] = k[31:0] ^ t;
        for (int i = 1; i < 4; i++)
            o[32*i +: 32] = k[32*i +: 32] ^ o[32*(i-1) +: 32];
        o[159:128] = k[159:128] ^ sub_word(o[127:96]);
        for (int i = 5; i < 8; i++)
            o[32*i +: 32] = k[32*i +: 32] ^ o[32*(i-1) +: 32];
        return o;
    endfunction

endpackage

// ----- src/rijndael256_block_encrypt_top.sv -----
// Rijndael-256 (256-bit block, 256-bit key) ECB encryption pipeline top level
// Usage:
//   Load the key through cfg_we/cfg_index/cfg_data (index 0..3 = key bytes
//   0-7, 8-15, 16-23, 24-31), then stream blocks on s_axis; ciphertext
//   leaves on m_axis in order. Key writes are allowed only while idle; the
//   schedule settles once the last write has run through every registered schedule group.
//   Pipeline: input AddRoundKey stage plus one stage per round; an item
//   accepted on s_axis leaves from the last round stage on m_axis. The
//   round-key chain is one registered stage per 8-word schedule group.
//   Throughput: one item per cycle while the pipeline is not stalled.
//   Stall: the whole pipeline holds while the output stage is full and
//   m_axis_tready is low; bubbles travel along with the items and are not
//   compacted. s_axis_tready = !m_axis_tvalid || m_axis_tready.
//   Reset clears all valid bits and the key registers to zero.
module rijndael256_block_encrypt_top #(
    parameter int NUM_ROUNDS = rd256_pkg::NumRoundsDefault
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rd256_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [63:0]                         cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // plain_bytes_0_7, plain_bytes_8_15, plain_bytes_16_23, plain_bytes_24_31
    input  logic [255:0]                        s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // cipher_bytes_0_7, cipher_bytes_8_15, cipher_bytes_16_23, cipher_bytes_24_31
    output logic [255:0]                        m_axis_tdata
);
    import rd256_pkg::*;

    logic [63:0] key_reg [KeyRegCount];
    block_t      cipher_key;
    block_t [NUM_ROUNDS:0] rnd_keys;

    logic   en;
    logic   v   [NUM_ROUNDS+1];
    block_t st  [NUM_ROUNDS+1];
    logic   v0_reg;
    block_t st0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KeyRegCount; i++)
                key_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_0_7:   key_reg[0] <= cfg_data;
                REG_KEY_8_15:  key_reg[1] <= cfg_data;
                REG_KEY_16_23: key_reg[2] <= cfg_data;
                REG_KEY_24_31: key_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cipher_key = {key_reg[3], key_reg[2], key_reg[1], key_reg[0]};

    rd256_keyexp #(.NUM_ROUNDS(NUM_ROUNDS)) u_keyexp (
        .clk        (clk),
        .cipher_key (cipher_key),
        .rnd_keys   (rnd_keys)
    );

    // single global enable: every stage moves when the output can drain
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            st0_reg <= s_axis_tdata ^ rnd_keys[0];
    end

    assign v[0]  = v0_reg;
    assign st[0] = st0_reg;

    for (genvar r = 1; r <= NUM_ROUNDS; r++)
    begin : g_round
        rd256_round #(.LAST(r == NUM_ROUNDS)) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (v[r-1]),
            .in_state  (st[r-1]),
            .round_key (rnd_keys[r]),
            .out_valid (v[r]),
            .out_state (st[r])
        );
    end

    assign m_axis_tvalid = v[NUM_ROUNDS];
    assign m_axis_tdata  = st[NUM_ROUNDS];

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output item changed while stalled");
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output item dropped while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output stage");
    a_first_stage: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> v0_reg)
        else $error("accepted item not captured");

endmodule

// ----- src/rd256_keyexp.sv -----
// Key schedule: expands the key registers into all round keys
module rd256_keyexp #(
    parameter int NUM_ROUNDS = rd256_pkg::NumRoundsDefault
) (
    input  logic                            clk,
    input  rd256_pkg::block_t               cipher_key,
    output rd256_pkg::block_t [NUM_ROUNDS:0] rnd_keys
);
    import rd256_pkg::*;

    // one 8-word schedule group per round key (block is 8 columns wide)
    localparam int Groups = NUM_ROUNDS + 1;

    // group regs; user keeps key static while items in flight (unchecked)
    block_t grp_reg [Groups];
    byte_t  rcon    [Groups];

    always_comb
    begin
        rcon[0] = 8'h01;
        for (int g = 1; g < Groups; g++)
            rcon[g] = xtime(rcon[g-1]);
    end

    always_ff @(posedge clk)
    begin
        grp_reg[0] <= cipher_key;
        for (int g = 1; g < Groups; g++)
            grp_reg[g] <= next_keys(grp_reg[g-1], rcon[g-1]);
    end

    always_comb
    begin
        for (int r = 0; r <= NUM_ROUNDS; r++)
            rnd_keys[r] = grp_reg[r];
    end

endmodule

// ----- src/rd256_round.sv -----
// One registered cipher round stage
module rd256_round #(
    parameter bit LAST = 1'b0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  rd256_pkg::block_t in_state,
    input  rd256_pkg::block_t round_key,
    output logic              out_valid,
    output rd256_pkg::block_t out_state
);
    import rd256_pkg::*;

    block_t state_reg;
    logic   valid_reg;
    block_t state_next;
    block_t ss;

    always_comb
    begin
        ss = sub_shift(in_state);
        state_next = (LAST ? ss : mix_cols(ss)) ^ round_key;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            state_reg <= state_next;
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;

endmodule

// ----- sim/tb_rijndael256_block_encrypt_top.sv -----
// Testbench for the Rijndael-256 ECB encryption pipeline: predictor-checked block stream
module tb_rijndael256_block_encrypt_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rd256_pkg::*;

    localparam int ROUNDS    = 14;
    localparam int PIPE_LAT  = ROUNDS + 1;
    localparam int KEY_SETTLE = 20;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD = 200;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [63:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [255:0] m_axis_tdata;

    rijndael256_block_encrypt_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    byte_t       sbox_tab [256];
    logic [63:0] key_words [4];
    block_t      cipher_q [$];
    int          mismatches;
    int          cycles;
    bit          tx_gaps;
    bit          rx_gaps;
    bit          hold_req;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic byte_t gf_mul(input byte_t a, input byte_t b);
        byte_t p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    // S-box from the field inverse and the affine map
    task automatic build_sbox();
        byte_t inv;
        for (int a = 0; a < 256; a++)
        begin
            inv = 8'h00;
            for (int b = 1; b < 256; b++)
                if (gf_mul(byte_t'(a), byte_t'(b)) == 8'h01)
                    inv = byte_t'(b);
            sbox_tab[a] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                        ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        end
    endtask

    function automatic byte_t dbl(input byte_t a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic block_t encrypt_block(input block_t plain);
        byte_t  sched [8*(ROUNDS+1)][4];
        byte_t  st [32];
        byte_t  tmp [32];
        byte_t  t [4];
        byte_t  t0, rc, a0, a1, a2, a3, al;
        int     shift [4];
        block_t res;
        shift = '{0, 1, 3, 4};
        rc = 8'h01;
        for (int i = 0; i < 8; i++)
            for (int k = 0; k < 4; k++)
                sched[i][k] = key_words[(4*i+k)/8][8*((4*i+k)%8) +: 8];
        for (int i = 8; i < 8*(ROUNDS+1); i++)
        begin
            t = sched[i-1];
            if (i % 8 == 0)
            begin
                t0 = t[0];
                t[0] = sbox_tab[t[1]] ^ rc;
                t[1] = sbox_tab[t[2]];
                t[2] = sbox_tab[t[3]];
                t[3] = sbox_tab[t0];
                rc = dbl(rc);
            end
            else if (i % 8 == 4)
                for (int k = 0; k < 4; k++)
                    t[k] = sbox_tab[t[k]];
            for (int k = 0; k < 4; k++)
                sched[i][k] = sched[i-8][k] ^ t[k];
        end
        for (int n = 0; n < 32; n++)
            st[n] = plain[8*n +: 8] ^ sched[n/4][n%4];
        for (int rnd = 1; rnd <= ROUNDS; rnd++)
        begin
            for (int n = 0; n < 32; n++)
                tmp[n] = sbox_tab[st[n]];
            for (int c = 0; c < 8; c++)
                for (int r = 0; r < 4; r++)
                    st[4*c+r] = tmp[4*((c + shift[r]) % 8) + r];
            if (rnd < ROUNDS)
                for (int c = 0; c < 8; c++)
                begin
                    a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    st[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
                    st[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
                    st[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
                    st[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
                end
            for (int n = 0; n < 32; n++)
                st[n] ^= sched[8*rnd + n/4][n%4];
        end
        for (int n = 0; n < 32; n++)
            res[8*n +: 8] = st[n];
        return res;
    endfunction

    function automatic block_t rand_block();
        block_t b;
        for (int i = 0; i < 8; i++)
            b[32*i +: 32] = $urandom;
        return b;
    endfunction

    task automatic send_block(input block_t blk);
        if (tx_gaps && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= blk;
        do
            @(posedge clk);
        while (!s_axis_tready);
        cipher_q.push_back(encrypt_block(blk));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (cipher_q.size() != 0)
            @(posedge clk);
    endtask

    // drain the outstanding items, wait out the pipeline, write, let the schedule settle
    task automatic load_key(input logic [63:0] k0, k1, k2, k3);
        logic [1:0] idx [4];
        idx = '{REG_KEY_0_7, REG_KEY_8_15, REG_KEY_16_23, REG_KEY_24_31};
        drain();
        repeat (PIPE_LAT + 2) @(posedge clk);
        key_words = '{k0, k1, k2, k3};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= key_words[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        repeat (KEY_SETTLE) @(posedge clk);
    endtask

    // receiver: random stall bursts, plus a long hold on request
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (rx_gaps && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(posedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (cipher_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: %h", m_axis_tdata);
            end
            else
            begin
                block_t want;
                want = cipher_q.pop_front();
                for (int f = 0; f < 4; f++)
                    if (m_axis_tdata[64*f +: 64] !== want[64*f +: 64])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("cipher_bytes_%0d_%0d: expected %h got %h",
                                     8*f, 8*f+7, want[64*f +: 64], m_axis_tdata[64*f +: 64]);
                    end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        block_t dir_rows [8];
        block_t walk;
        mismatches    = 0;
        cycles        = 0;
        tx_gaps       = 1'b1;
        rx_gaps       = 1'b1;
        hold_req      = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_KEY_0_7;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        key_words     = '{64'h0, 64'h0, 64'h0, 64'h0};
        build_sbox();
        for (int i = 0; i < 32; i++)
            walk[8*i +: 8] = byte_t'(i);
        dir_rows = '{'0, '1, {32{8'haa}}, {32{8'h55}}, 256'h1, {1'b1, 255'h0},
                     walk, ~walk};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset key, all-ones key, patterned key
        for (int p = 0; p < 3; p++)
        begin
            if (p == 1)
                load_key('1, '1, '1, '1);
            else if (p == 2)
                load_key(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                         64'h1716151413121110, 64'h1f1e1d1c1b1a1918);
            foreach (dir_rows[i])
                send_block(dir_rows[i]);
        end

        // receiver holds off while items keep coming, so the pipeline backs up
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
            send_block(rand_block());
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            load_key({$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom});
            if (ph == 5)
            begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            for (int i = 0; i < 230; i++)
                send_block(rand_block());
        end

        drain();
        repeat (PIPE_LAT + 5) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
src/rd256_pkg.sv
src/rd256_keyexp.sv
src/rd256_round.sv
src/rijndael256_block_encrypt_top.sv
sim/tb_rijndael256_block_encrypt_top.sv
